### hw/rtl/tkms_pkg.sv
// Shared widths and constants for the top-k magnitude selector.
package tkms_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SQ_W       = 31;
    localparam int MAG_W      = 32;
    localparam int KEEP_CFG_W = 5;

    localparam logic [KEEP_CFG_W-1:0] KEEP_RESET = 5'd16;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

endpackage

### hw/rtl/tkms_front.sv
// Front end: sample intake, squared magnitude, index counter and keep-count register.
module tkms_front #(
    parameter int KEEP_MAX   = 16,
    parameter int INDEX_BITS = 20
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic signed [tkms_pkg::SAMPLE_W-1:0] i_sample_re,
    input  logic signed [tkms_pkg::SAMPLE_W-1:0] i_sample_im,
    input  logic                                 i_is_last,
    input  logic                                 i_cfg_we,
    input  logic [tkms_pkg::KEEP_CFG_W-1:0]      i_cfg_keep_count,
    output logic [$clog2(KEEP_MAX+1)-1:0]        o_keep_eff,
    output logic                                 o_q_push,
    input  logic                                 i_q_full,
    output logic [tkms_pkg::MAG_W-1:0]           o_q_mag,
    output logic [INDEX_BITS-1:0]                o_q_idx,
    output logic                                 o_q_ovf,
    output logic                                 o_q_last
);
    import tkms_pkg::*;

    localparam int KW = $clog2(KEEP_MAX + 1);
    localparam int CW = (KW > KEEP_CFG_W) ? KW : KEEP_CFG_W;
    localparam logic [CW-1:0] KMAX_C = CW'(KEEP_MAX);

    logic [KEEP_CFG_W-1:0]       r_keep_count;
    logic [CW-1:0]               cfg_ext;
    logic                        r_s1_vld;
    logic [SQ_W-1:0]             r_sq_re;
    logic [SQ_W-1:0]             r_sq_im;
    logic [INDEX_BITS-1:0]       r_s1_idx;
    logic                        r_s1_ovf;
    logic                        r_s1_last;
    logic [INDEX_BITS-1:0]       r_next_idx;
    logic                        r_ovf;
    logic signed [2*SAMPLE_W-1:0] sq_re;
    logic signed [2*SAMPLE_W-1:0] sq_im;
    logic                        accept;
    logic                        idx_max;

    // saturate the keep count into 1..KEEP_MAX
    assign cfg_ext = CW'(r_keep_count);
    always_comb begin
        if (r_keep_count == '0) begin
            o_keep_eff = KW'(1);
        end else if (cfg_ext > KMAX_C) begin
            o_keep_eff = KW'(KEEP_MAX);
        end else begin
            o_keep_eff = KW'(cfg_ext);
        end
    end

    assign o_full   = r_s1_vld && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_s1_vld && !i_q_full;
    assign idx_max  = (r_next_idx == '1);

    assign sq_re = i_sample_re * i_sample_re;
    assign sq_im = i_sample_im * i_sample_im;

    assign o_q_mag  = {1'b0, r_sq_re} + {1'b0, r_sq_im};
    assign o_q_idx  = r_s1_idx;
    assign o_q_ovf  = r_s1_ovf;
    assign o_q_last = r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_count <= KEEP_RESET;
            r_s1_vld     <= 1'b0;
            r_next_idx   <= '0;
            r_ovf        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_keep_count <= i_cfg_keep_count;
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (o_q_push) begin
                r_s1_vld <= 1'b0;
            end
            if (accept) begin
                if (i_is_last) begin
                    r_next_idx <= '0;
                    r_ovf      <= 1'b0;
                end else if (idx_max) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_next_idx <= r_next_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sq_re   <= sq_re[SQ_W-1:0];
            r_sq_im   <= sq_im[SQ_W-1:0];
            r_s1_idx  <= r_next_idx;
            r_s1_ovf  <= r_ovf | idx_max;
            r_s1_last <= i_is_last;
        end
    end

endmodule

### hw/rtl/tkms_fifo.sv
// Short queue between the front end and the sorting back end.
module tkms_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);
    import tkms_pkg::*;

    logic [DATA_W-1:0] r_mem [QDEPTH];
    logic [QAW-1:0]    r_wr_ptr;
    logic [QAW-1:0]    r_rd_ptr;
    logic [QCW-1:0]    r_count;
    logic [DATA_W-1:0] r_data;
    logic              r_data_vld;
    logic              load;

    // move the oldest stored word into the output register when it is free
    assign load    = (r_count != '0) && (!r_data_vld || i_pop);
    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_empty = !r_data_vld;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
            r_data_vld <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (load) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !load) begin
                r_count <= r_count + 1'b1;
            end else if (load && !i_push) begin
                r_count <= r_count - 1'b1;
            end
            if (load) begin
                r_data_vld <= 1'b1;
            end else if (i_pop) begin
                r_data_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (load) begin
            r_data <= r_mem[r_rd_ptr];
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == QCW'(QDEPTH)))
        else $error("queue written while full");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !r_data_vld))
        else $error("queue read while empty");

endmodule

### hw/rtl/tkms_back.sv
// Back end: parallel insertion chain of kept entries and result drain.
module tkms_back #(
    parameter int KEEP_MAX   = 16,
    parameter int INDEX_BITS = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [$clog2(KEEP_MAX+1)-1:0]  i_keep_eff,
    input  logic                           i_q_empty,
    output logic                           o_q_pop,
    input  logic [tkms_pkg::MAG_W-1:0]     i_q_mag,
    input  logic [INDEX_BITS-1:0]          i_q_idx,
    input  logic                           i_q_ovf,
    input  logic                           i_q_last,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [INDEX_BITS-1:0]          o_rank_index,
    output logic [tkms_pkg::MAG_W-1:0]     o_rank_mag_sq,
    output logic                           o_count_overflow,
    output logic                           o_last_result
);
    import tkms_pkg::*;

    localparam int KW = $clog2(KEEP_MAX + 1);

    typedef enum logic {S_RUN, S_DRAIN} t_state;

    t_state                r_state;
    logic [MAG_W-1:0]      r_mag [KEEP_MAX];
    logic [MAG_W-1:0]      n_mag [KEEP_MAX];
    logic [INDEX_BITS-1:0] r_idx [KEEP_MAX];
    logic [INDEX_BITS-1:0] n_idx [KEEP_MAX];
    logic [KEEP_MAX-1:0]   r_vld;
    logic [KEEP_MAX-1:0]   n_vld;
    logic [KEEP_MAX-1:0]   v_eff;
    logic [KEEP_MAX-1:0]   ge;
    logic [KEEP_MAX-1:0]   ge_up;
    logic [KEEP_MAX-1:0]   v_up;
    logic [KW-1:0]         r_cnt;
    logic                  r_ovf;
    logic                  r_out_vld;
    logic [INDEX_BITS-1:0] r_out_idx;
    logic [MAG_W-1:0]      r_out_mag;
    logic                  r_out_ovf;
    logic                  r_out_last;
    logic                  ins;
    logic                  shift;
    logic                  drain_end;

    assign ins       = (r_state == S_RUN) && !i_q_empty;
    assign shift     = (r_state == S_DRAIN) && (!r_out_vld || i_pop);
    assign drain_end = ((r_cnt + KW'(1)) == i_keep_eff);
    assign o_q_pop   = ins;

    // Entries are held largest first in a valid prefix; a slot at or past
    // the keep count counts as dropped.
    always_comb begin
        for (int j = 0; j < KEEP_MAX; j++) begin
            v_eff[j] = r_vld[j] && (KW'(j) < i_keep_eff);
            ge[j]    = v_eff[j] && (r_mag[j] >= i_q_mag);
        end
        ge_up = KEEP_MAX'({ge, 1'b1});
        v_up  = KEEP_MAX'({v_eff, 1'b0});

        n_mag = r_mag;
        n_idx = r_idx;
        n_vld = r_vld;

        if (ins) begin
            for (int j = 0; j < KEEP_MAX; j++) begin
                if (!(KW'(j) < i_keep_eff)) begin
                    n_vld[j] = 1'b0;
                end else if (ge[j]) begin
                    n_vld[j] = 1'b1;
                end else if (ge_up[j]) begin
                    n_mag[j] = i_q_mag;
                    n_idx[j] = i_q_idx;
                    n_vld[j] = 1'b1;
                end else begin
                    n_vld[j] = v_up[j];
                end
            end
            for (int j = 1; j < KEEP_MAX; j++) begin
                if ((KW'(j) < i_keep_eff) && !ge[j] && !ge_up[j]) begin
                    n_mag[j] = r_mag[j-1];
                    n_idx[j] = r_idx[j-1];
                end
            end
        end else if (shift) begin
            // advance the list toward slot 0, largest goes out first
            for (int j = 0; j + 1 < KEEP_MAX; j++) begin
                n_mag[j] = r_mag[j+1];
                n_idx[j] = r_idx[j+1];
            end
            n_vld = r_vld >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_vld     <= '0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
            case (r_state)
                S_RUN: begin
                    if (ins && i_q_last) begin
                        r_state <= S_DRAIN;
                        r_cnt   <= '0;
                        r_ovf   <= i_q_ovf;
                    end
                end
                S_DRAIN: begin
                    if (shift) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (drain_end) begin
                            r_state <= S_RUN;
                        end
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
            if (shift) begin
                r_out_vld  <= 1'b1;
                r_out_idx  <= r_vld[0] ? r_idx[0] : '0;
                r_out_mag  <= r_vld[0] ? r_mag[0] : '0;
                r_out_ovf  <= r_ovf;
                r_out_last <= drain_end;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_idx <= n_idx;
    end

    assign o_empty          = !r_out_vld;
    assign o_rank_index     = r_out_idx;
    assign o_rank_mag_sq    = r_out_mag;
    assign o_count_overflow = r_out_ovf;
    assign o_last_result    = r_out_last;

    a_vld_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld & KEEP_MAX'(r_vld + 1'b1)) == '0)
        else $error("kept entries are not a contiguous prefix");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (shift && drain_end) |=> (r_vld == '0 && r_state == S_RUN))
        else $error("list not empty after the final result");

endmodule

### hw/rtl/top_k_magnitude_selector_unit.sv
// Top level of the top-k magnitude selector: front end, queue and sorting back end.
//
// Complex Q1.15 samples enter through a queue-style push/full port and are
// numbered from 0 within a data set. Each sample's squared magnitude
// (re*re + im*im, Q2.30) and index are ranked in a sorted list of the
// keep_count largest entries; a new entry lands below any equal ones, and
// once the list is full a sample enters only if strictly larger than the
// smallest kept entry. The sample flagged is_last is ranked too, then the
// list is read out largest first as keep_count results on the empty/pop
// port, the last carrying last_result; slots never filled read out as
// index 0, magnitude 0. The index counter stops at its top value and sets
// count_overflow for the rest of the set. Path: a sample sits in the front
// end stage (squares registered on the transfer, summed on the way into
// the queue), then in the queue (write, then registered read into its
// output register); the back end ranks it on the edge that pops it, where
// a chain of compare cells inserts one entry per cycle, so a set streams
// at one sample per cycle while no earlier set is being drained.
// Once the sample marked is_last is ranked, the back end stops taking
// samples until all keep_count results have shifted out, longer while pop
// is held low, as the list shifts out one result per cycle through the
// output register, the first as soon as that register is free or popped.
// During that time the front end keeps taking samples until its stage,
// the four-entry queue and the queue's output register are full.
// Set keep_count only while the block is idle; 0 acts as 1 and values
// above KEEP_MAX act as KEEP_MAX. Lowering it mid-set drops the smallest
// kept entries on the next sample.
module top_k_magnitude_selector_unit #(
    parameter int KEEP_MAX   = 16,
    parameter int INDEX_BITS = 20
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [tkms_pkg::SAMPLE_W-1:0] i_sample_re,
    input  logic signed [tkms_pkg::SAMPLE_W-1:0] i_sample_im,
    input  logic                                 i_is_last,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [INDEX_BITS-1:0]                o_rank_index,
    output logic [tkms_pkg::MAG_W-1:0]           o_rank_mag_sq,
    output logic                                 o_count_overflow,
    output logic                                 o_last_result,
    input  logic                                 i_keep_count_we,
    input  logic [tkms_pkg::KEEP_CFG_W-1:0]      i_keep_count
);
    import tkms_pkg::*;

    localparam int KW = $clog2(KEEP_MAX + 1);
    // queue word: magnitude, index, overflow, last
    localparam int QW = MAG_W + INDEX_BITS + 2;

    logic [KW-1:0]         keep_eff;
    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_empty;
    logic [MAG_W-1:0]      f_mag;
    logic [INDEX_BITS-1:0] f_idx;
    logic                  f_ovf;
    logic                  f_last;
    logic [QW-1:0]         q_wdata;
    logic [QW-1:0]         q_rdata;

    tkms_front #(
        .KEEP_MAX   (KEEP_MAX),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_sample_re      (i_sample_re),
        .i_sample_im      (i_sample_im),
        .i_is_last        (i_is_last),
        .i_cfg_we         (i_keep_count_we),
        .i_cfg_keep_count (i_keep_count),
        .o_keep_eff       (keep_eff),
        .o_q_push         (q_push),
        .i_q_full         (q_full),
        .o_q_mag          (f_mag),
        .o_q_idx          (f_idx),
        .o_q_ovf          (f_ovf),
        .o_q_last         (f_last)
    );

    assign q_wdata = {f_mag, f_idx, f_ovf, f_last};

    // decouple the front end from the back end while it drains a set
    tkms_fifo #(
        .DATA_W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    tkms_back #(
        .KEEP_MAX   (KEEP_MAX),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_keep_eff       (keep_eff),
        .i_q_empty        (q_empty),
        .o_q_pop          (q_pop),
        .i_q_mag          (q_rdata[QW-1 -: MAG_W]),
        .i_q_idx          (q_rdata[INDEX_BITS+1:2]),
        .i_q_ovf          (q_rdata[1]),
        .i_q_last         (q_rdata[0]),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_rank_index     (o_rank_index),
        .o_rank_mag_sq    (o_rank_mag_sq),
        .o_count_overflow (o_count_overflow),
        .o_last_result    (o_last_result)
    );

endmodule
